// File: design/npr_pkg.sv
// npr_pkg: shared constants of the nearest prime rounder
// no dependencies; used by nearest_prime_rounder_core and npr_bitmap
package npr_pkg;

  // default depth of the primality bitmap
  localparam int TABLE_SIZE_DEF = 16384;

  // width of the value and result fields
  localparam int VAL_W = 16;

  // wide arithmetic width: holds sums of two in-table values and the sieve square
  localparam int WIDE_W = VAL_W + 2;

endpackage

// File: design/npr_bitmap.sv
// npr_bitmap: one-bit primality memory, one write port and two registered read ports
// depends on npr_pkg for the default depth
module npr_bitmap #(
  parameter int DEPTH  = npr_pkg::TABLE_SIZE_DEF,
  parameter int ADDR_W = $clog2(npr_pkg::TABLE_SIZE_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic              rdata_a,
  output logic              rdata_b
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/nearest_prime_rounder_core.sv
// nearest_prime_rounder_core: rounds a 16-bit value below TABLE_SIZE to the nearest prime
// depends on npr_pkg and npr_bitmap (primality memory)
//
// usage
//   input channel s_*: one 16-bit value per transfer on s_tdata
//   output channel m_*: one result per transfer, prime on m_tdata,
//   out-of-range flag on m_tuser
// reset
//   rst (synchronous, active high) starts the sieve: a fill pass writes
//   every bitmap entry (entries 0 and 1 cleared, the rest set),
//   then for each i from 2 with i*i < TABLE_SIZE the sequencer reads
//   bitmap[i] (states S_SQ and S_TEST) and, when i is prime, strikes out
//   each multiple of i from i*i upward; s_tready stays low until the sieve is done
// search
//   one value at a time; s_tready is high only when the sequencer is idle
//   an in-range value is searched at growing distance d until a prime is
//   found, nearest first: each search step reads the bitmap at
//   value - d and value + d through the two read ports of the memory
//   a value at or above TABLE_SIZE skips the search and is echoed with the flag
// stalls
//   a finished result waits in the output register while m_tready is low;
//   a following search runs meanwhile and holds its result until the
//   output register is free
module nearest_prime_rounder_core #(
  parameter int TABLE_SIZE = npr_pkg::TABLE_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [npr_pkg::VAL_W-1:0] s_tdata,   // [15:0] value
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [npr_pkg::VAL_W-1:0] m_tdata,   // [15:0] prime
  output logic                      m_tuser    // [0] out_of_range
);

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  // sieve index wide enough to reach the first i with i*i >= TABLE_SIZE
  localparam int I_W    = (ADDR_W + 1) / 2 + 1;
  localparam int W      = npr_pkg::WIDE_W;
  localparam int VAL_W  = npr_pkg::VAL_W;

  localparam logic [W-1:0]      LIMIT    = W'(TABLE_SIZE);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,   // initial fill of the bitmap
    S_SQ,      // square the sieve index, read its bitmap entry
    S_TEST,    // decide whether to strike out multiples
    S_MARK,    // strike out one multiple per cycle
    S_IDLE,    // ready for a value
    S_SEARCH,  // widen the search window by one each cycle
    S_EMIT     // hand the result to the output register
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] clr_cnt;
  logic [I_W-1:0]    idx;
  logic [W-1:0]      sq;
  logic [W-1:0]      mult;
  logic [VAL_W-1:0]  val;
  logic [W-1:0]      span;
  logic [VAL_W-1:0]  res;
  logic              res_oor;

  // memory ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic              rdata_a;
  logic              rdata_b;

  // search arithmetic
  logic [W-1:0] val_w;
  logic [W-1:0] idx_w;
  logic [W-1:0] lo_addr;
  logic [W-1:0] hi_addr;
  logic [W-1:0] span_chk;
  logic [W-1:0] chk_lo;
  logic [W-1:0] chk_hi;
  logic         lo_ok;
  logic         hi_ok;
  logic [W-1:0] mult_next;
  logic [W-1:0] in_w;
  logic         accept;
  logic         out_free;

  assign val_w     = W'(val);
  assign idx_w     = W'(idx);
  assign in_w      = W'(s_tdata);
  assign lo_addr   = val_w - span;
  assign hi_addr   = val_w + span;
  // read data in S_SEARCH belongs to the window issued in the previous cycle
  assign span_chk  = span - W'(1);
  assign chk_lo    = val_w - span_chk;
  assign chk_hi    = val_w + span_chk;
  assign lo_ok     = val_w >= (span_chk + W'(2));
  assign hi_ok     = chk_hi < LIMIT;
  assign mult_next = mult + idx_w;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // read address selection
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    unique case (state)
      S_SQ: begin
        raddr_a = idx_w[ADDR_W-1:0];
      end
      S_IDLE: begin
        raddr_a = s_tdata[ADDR_W-1:0];
        raddr_b = s_tdata[ADDR_W-1:0];
      end
      S_SEARCH: begin
        raddr_a = lo_addr[ADDR_W-1:0];
        raddr_b = hi_addr[ADDR_W-1:0];
      end
      default: begin
        raddr_a = '0;
        raddr_b = '0;
      end
    endcase
  end

  // write port: fill pass, then striking out multiples
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = (clr_cnt > ADDR_W'(1));
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = mult[ADDR_W-1:0];
        mem_wdata = 1'b0;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  npr_bitmap #(
    .DEPTH  (TABLE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_bitmap (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      idx      <= I_W'(2);
      m_tvalid <= 1'b0;
    end else begin
      // S_EMIT drives m_tvalid itself
      if (m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == LAST_IDX) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq    <= W'(idx_w * idx_w);
          state <= S_TEST;
        end
        S_TEST: begin
          if (sq >= LIMIT) begin
            state <= S_IDLE;
          end else if (rdata_a) begin
            mult  <= sq;
            state <= S_MARK;
          end else begin
            idx   <= idx + I_W'(1);
            state <= S_SQ;
          end
        end
        S_MARK: begin
          mult <= mult_next;
          if (mult_next >= LIMIT) begin
            idx   <= idx + I_W'(1);
            state <= S_SQ;
          end
        end
        S_IDLE: begin
          if (accept) begin
            val <= s_tdata;
            if (in_w >= LIMIT) begin
              // out of table: echo the value
              res     <= s_tdata;
              res_oor <= 1'b1;
              state   <= S_EMIT;
            end else begin
              span  <= W'(1);
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          res_oor <= 1'b0;
          if (lo_ok && rdata_a) begin
            // lower side first so the smaller prime wins a tie
            res   <= chk_lo[VAL_W-1:0];
            state <= S_EMIT;
          end else if (hi_ok && rdata_b) begin
            res   <= chk_hi[VAL_W-1:0];
            state <= S_EMIT;
          end else if (!lo_ok && !hi_ok) begin
            res   <= val;
            state <= S_EMIT;
          end else begin
            span <= span + W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            m_tuser  <= res_oor;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
